>>> rtl/afb_pkg.sv
`default_nettype none
package afb_pkg;

  localparam int SEGMENTS_DEF = 32;
  localparam int ONE_Q12      = 4096;
  localparam int X_SPAN       = 32768;
  localparam int TAYLOR_TERMS = 20;
  localparam int Q30_SH       = 30;

  typedef enum logic [1:0] {
    MODE_RELU_FWD = 2'd0,
    MODE_RELU_BWD = 2'd1,
    MODE_SIG_FWD  = 2'd2,
    MODE_SIG_BWD  = 2'd3
  } mode_t;

  // Enables for the two register stages of the constant divider
  typedef struct packed {
    logic s1;
    logic s2;
  } div_en_t;

  // Restoring shift-subtract quotient, evaluated at elaboration only
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(4096 * sigmoid(num / 4096)), evaluated at elaboration only
  function automatic logic [12:0] sig_point(input longint unsigned num);
    longint unsigned h;
    longint unsigned term;
    longint unsigned e;
    longint unsigned den;
    longint unsigned q;
    longint          sum;
    h    = num << 14;
    term = 64'd1 << Q30_SH;
    sum  = longint'(term);
    for (int i = 1; i <= TAYLOR_TERMS; i++) begin
      term = udiv64((term * h) >> Q30_SH, 64'(i));
      if (i[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    e = (sum < 0) ? 64'd0 : longint'(sum);
    for (int j = 0; j < 4; j++) begin
      e = (e * e + (64'd1 << (Q30_SH - 1))) >> Q30_SH;
    end
    den = (64'd1 << Q30_SH) + e;
    q   = udiv64((64'd1 << 43) + den, den << 1);
    return 13'(q);
  endfunction

endpackage
`default_nettype wire

>>> rtl/afb_const_div.sv
`default_nettype none
// Two-stage divide by a constant: reciprocal multiply, then one correction step.
module afb_const_div #(
  parameter int NUM_W = 16,
  parameter int DIV   = 1024,
  parameter int QUO_W = 6,
  parameter int REM_W = 10
) (
  input  wire                    clk,
  input  wire afb_pkg::div_en_t  en,
  input  wire        [NUM_W-1:0] num_i,
  output logic       [QUO_W-1:0] quo_o,
  output logic       [REM_W-1:0] rem_o
);
  import afb_pkg::*;

  localparam longint RECIP = (64'd1 << NUM_W) / DIV;
  localparam int     MW    = $clog2(RECIP + 1);
  localparam int     PW    = NUM_W + MW + QUO_W;

  logic [PW-1:0]    prod;
  logic [QUO_W-1:0] q0_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] rem_raw;
  logic [QUO_W-1:0] quo_nxt;
  logic [REM_W-1:0] rem_nxt;

  // q0 never exceeds the true quotient and trails it by at most one
  assign prod = PW'(num_i) * PW'(RECIP);

  always_comb begin
    rem_raw = num_r - NUM_W'(NUM_W'(q0_r) * NUM_W'(DIV));
    if (rem_raw >= NUM_W'(DIV)) begin
      quo_nxt = q0_r + QUO_W'(1);
      rem_nxt = REM_W'(rem_raw - NUM_W'(DIV));
    end else begin
      quo_nxt = q0_r;
      rem_nxt = REM_W'(rem_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      q0_r  <= prod[NUM_W +: QUO_W];
      num_r <= num_i;
    end
    if (en.s2) begin
      quo_o <= quo_nxt;
      rem_o <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/activation_fwd_bwd_unit.sv
`default_nettype none
// Element-wise activation engine in signed Q4.12 (1.0 = 4096).
// Input stream in_*: one beat per element; in_tdata carries act_in and grad_out,
// in_tlast marks the final element of a batch and is copied to out_tlast.
// Output stream out_*: one beat per input beat, same order; out_tdata is the
// saturated activation or input gradient.
// cfg_wr_en/cfg_wr_data write the 2-bit mode (relu fwd, relu bwd, logistic
// fwd, logistic bwd); write it only while the pipeline is empty.
// Throughput: one beat per cycle while the receiver accepts, set by a
// ten-stage pipeline with a stage-by-stage ready chain:
// reciprocal divide of |x| by the segment width (2 stages), sigmoid ROM read,
// slope multiply, reciprocal divide for the interpolation (2 stages),
// mirror for negative x, y*(1-y), gradient multiply, round/saturate/select.
// A stalled receiver holds the output beat; upstream stages keep filling
// bubbles and in_tready drops only once every stage holds a beat.
// Reset (rst_n low at a clock edge) empties the pipeline and sets mode to
// relu forward. The sigmoid table is a constant, built at elaboration.
module activation_fwd_bwd_unit #(
  parameter int SEGMENTS = afb_pkg::SEGMENTS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [1:0]  cfg_wr_data,   // mode
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,      // [15:0] act_in, [31:16] grad_out
  input  wire         in_tlast,      // last_in
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,     // [15:0] result_value
  output logic        out_tlast      // last_out
);
  import afb_pkg::*;

  localparam int SEG_W    = (X_SPAN + SEGMENTS - 1) / SEGMENTS;
  localparam int HALF_SEG = SEG_W / 2;
  localparam int IDX_W    = $clog2(SEGMENTS + 1);
  localparam int F_W      = $clog2(SEG_W);
  localparam int A_W      = 16;
  localparam int Y_W      = 13;
  localparam int D_W      = 12;
  localparam int N_W      = D_W + F_W + 1;
  localparam int Q_W      = 12;
  localparam int P_W      = 24;
  localparam int PR_W     = 40;
  localparam int NSTG     = 10;

  typedef logic [Y_W-1:0] rom_t [SEGMENTS+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= SEGMENTS; k++) begin
      r[k] = sig_point(longint'(k) * longint'(SEG_W));
    end
    return r;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  mode_t mode_r;

  logic [NSTG:1]    v_r;
  logic [NSTG:1]    en;
  logic [15:0]      x_r    [1:NSTG-1];
  logic [15:0]      g_r    [1:NSTG-1];
  logic             last_r [1:NSTG];

  logic [15:0]      in_x;
  logic [15:0]      in_g;
  logic [A_W-1:0]   in_abs;

  logic [IDX_W-1:0] idx_s2;
  logic [F_W-1:0]   f_s2;
  logic [IDX_W-1:0] nidx;

  logic [Y_W-1:0]   y0_r3;
  logic [Y_W-1:0]   y1_r3;
  logic [F_W-1:0]   f_r3;
  logic [Y_W-1:0]   y0_r4;
  logic [N_W-1:0]   n_r4;
  logic [N_W-1:0]   n_nxt;
  logic [D_W-1:0]   slope;
  logic [Y_W-1:0]   y0_r5;
  logic [Y_W-1:0]   y0_r6;
  logic [Q_W-1:0]   q_s6;

  logic [Y_W-1:0]   yp;
  logic [Y_W-1:0]   y_r7;
  logic [Y_W-1:0]   y_nxt;
  logic [Y_W-1:0]   y_r8;
  logic [Y_W-1:0]   y_r9;
  logic [P_W-1:0]   p_r8;
  logic [P_W-1:0]   p_nxt;
  logic signed [PR_W-1:0] prod_r9;
  logic signed [PR_W-1:0] prod_nxt;
  logic signed [P_W+16:0] prod_full;

  logic [PR_W-1:0]  mag;
  logic [PR_W-1:0]  mag_rnd;
  logic [15:0]      rnd;
  logic signed [16:0] bwd_val;
  logic [15:0]      res_nxt;
  logic [15:0]      res_r;

  assign in_x   = in_tdata[15:0];
  assign in_g   = in_tdata[31:16];
  assign in_abs = in_x[15] ? A_W'(-in_x) : A_W'(in_x);

  // Ready chain: a stage may load when it is empty or its successor moves
  always_comb begin
    en[NSTG] = !v_r[NSTG] || out_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = v_r[NSTG];
  assign out_tdata  = res_r;
  assign out_tlast  = last_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RELU_FWD;
      v_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= mode_t'(cfg_wr_data);
      end
      if (en[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Side payload shift line: x, grad and last ride along with each beat
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_r[1]    <= in_x;
      g_r[1]    <= in_g;
      last_r[1] <= in_tlast;
    end
    for (int k = 2; k <= NSTG - 1; k++) begin
      if (en[k]) begin
        x_r[k] <= x_r[k-1];
        g_r[k] <= g_r[k-1];
      end
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (en[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // Stages 1-2: segment index and offset of |x|
  afb_const_div #(
    .NUM_W (A_W),
    .DIV   (SEG_W),
    .QUO_W (IDX_W),
    .REM_W (F_W)
  ) u_seg_div (
    .clk   (clk),
    .en    ('{s1: en[1], s2: en[2]}),
    .num_i (in_abs),
    .quo_o (idx_s2),
    .rem_o (f_s2)
  );

  // The top segment has no right neighbor; its offset is always zero there
  assign nidx = (idx_s2 == IDX_W'(SEGMENTS)) ? idx_s2 : idx_s2 + IDX_W'(1);

  // Stage 3: table read of both segment ends
  always_ff @(posedge clk) begin
    if (en[3]) begin
      y0_r3 <= SIG_ROM[idx_s2];
      y1_r3 <= SIG_ROM[nidx];
      f_r3  <= f_s2;
    end
  end

  // Stage 4: slope times offset, plus half a segment for rounding
  assign slope = D_W'(y1_r3 - y0_r3);
  assign n_nxt = N_W'(N_W'(slope) * N_W'(f_r3)) + N_W'(HALF_SEG);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      n_r4  <= n_nxt;
      y0_r4 <= y0_r3;
    end
  end

  // Stages 5-6: interpolation step divided by the segment width
  afb_const_div #(
    .NUM_W (N_W),
    .DIV   (SEG_W),
    .QUO_W (Q_W),
    .REM_W (F_W)
  ) u_interp_div (
    .clk   (clk),
    .en    ('{s1: en[5], s2: en[6]}),
    .num_i (n_r4),
    .quo_o (q_s6),
    .rem_o ()
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      y0_r5 <= y0_r4;
    end
    if (en[6]) begin
      y0_r6 <= y0_r5;
    end
  end

  // Stage 7: mirror around one half for negative inputs
  assign yp    = y0_r6 + Y_W'(q_s6);
  assign y_nxt = x_r[6][15] ? Y_W'(ONE_Q12) - yp : yp;

  // Stage 8: y * (1 - y) in Q24
  assign p_nxt = P_W'(P_W'(y_r7) * P_W'(Y_W'(ONE_Q12) - y_r7));

  // Stage 9: gradient times derivative
  always_comb begin
    prod_full = $signed(g_r[8]) * $signed({1'b0, p_r8});
    prod_nxt  = PR_W'(prod_full);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      y_r7 <= y_nxt;
    end
    if (en[8]) begin
      y_r8 <= y_r7;
      p_r8 <= p_nxt;
    end
    if (en[9]) begin
      y_r9    <= y_r8;
      prod_r9 <= prod_nxt;
    end
  end

  // Stage 10: round half away from zero, saturate, select by mode
  always_comb begin
    mag     = prod_r9[PR_W-1] ? PR_W'(-prod_r9) : PR_W'(prod_r9);
    mag_rnd = mag + (PR_W'(1) << 23);
    rnd     = mag_rnd[39:24];
    bwd_val = prod_r9[PR_W-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    case (mode_r)
      MODE_RELU_FWD: begin
        res_nxt = ($signed(x_r[9]) > 16'sd0) ? x_r[9] : 16'd0;
      end
      MODE_RELU_BWD: begin
        res_nxt = ($signed(x_r[9]) > 16'sd0) ? g_r[9] : 16'd0;
      end
      MODE_SIG_FWD: begin
        res_nxt = 16'(y_r9);
      end
      MODE_SIG_BWD: begin
        if (bwd_val > 17'sd32767) begin
          res_nxt = 16'h7fff;
        end else if (bwd_val < -17'sd32768) begin
          res_nxt = 16'h8000;
        end else begin
          res_nxt = bwd_val[15:0];
        end
      end
      default: begin
        res_nxt = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire
